[sv/multivoice_pcm_mixer_defines.svh]
// Assertion macros used by the port checker of the PCM mixer.
// Depends on nothing; the asserting module must have i_clk and i_rst_n.
`ifndef MULTIVOICE_PCM_MIXER_DEFINES_SVH
`define MULTIVOICE_PCM_MIXER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MVPM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mixer port check failed");

// Next-cycle implication, checked outside reset.
`define MVPM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mixer port check failed");

`endif

[sv/mvpm_pkg.sv]
// Shared types, codes and constants of the multi-voice PCM mixer.
// Depends on nothing; used by the top level and the checker of the mixer.
package mvpm_pkg;

    localparam int VOICE_COUNT_DEF      = 16;
    localparam int SAMPLE_ADDR_BITS_DEF = 16;

    // Item kinds carried on tuser.
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_MIX   = 2'd2;
    localparam logic [1:0] KIND_STOP  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ACTIVE_VOICES  = 2'd0;
    localparam logic [1:0] CFG_MASTER_VOLUME  = 2'd1;
    localparam logic [1:0] CFG_EIGHT_BIT_MODE = 2'd2;

    localparam logic [4:0] ACTIVE_VOICES_RST = 5'd8;
    localparam logic [4:0] MASTER_VOLUME_RST = 5'd31;

    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 64;
    localparam int ACC_W       = 32;

    // Reciprocal multipliers: x/31 = (x*DIV31_MUL)>>20 for x < 4096,
    // 256*p/127 = (p*DIV127_MUL)>>22 for p < 16384.
    localparam logic [15:0] DIV31_MUL  = 16'd33826;
    localparam logic [23:0] DIV127_MUL = 24'd8454661;

    localparam logic [30:0] TICK_MAX = 31'h7fffffff;
    localparam logic [7:0]  SILENCE  = 8'd128;
    localparam logic [6:0]  LEVEL_MAX = 7'd127;

    typedef struct packed {
        logic [15:0] base;
        logic [16:0] position;
        logic [15:0] end_pos;
        logic [17:0] rate;
        logic [15:0] fraction;
        logic [30:0] started;
        logic [15:0] sound;
        logic [15:0] tag;
        logic [6:0]  left_level;
        logic [6:0]  right_level;
    } t_voice;

    function automatic logic [15:0] sat16(input logic signed [ACC_W-1:0] v);
        logic [15:0] r;
        if (v > $signed(ACC_W'(32'sh7fff))) begin
            r = 16'h7fff;
        end else if (v < $signed(-ACC_W'(32'sh8000))) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

[sv/mvpm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module mvpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/multivoice_pcm_mixer.sv]
// Top level of the multi-voice PCM mixer: sequencer, voice table and mixing datapath.
// Depends on mvpm_pkg and mvpm_ram.
//
//  Channel   Direction  Handshake                      Contents
//  s_axis    in         s_axis_tvalid / s_axis_tready  tuser kind, tdata item fields
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata result fields
//  cfg       in         i_cfg_we                       i_cfg_index, i_cfg_data
//
// A sample write stores its byte and then issues a result. A start scans the voices in use
// and then forms the pan levels, which share one 17x9 multiplier. A stop checks one voice.
// A frame steps through the voices in use; each live voice takes the voice
// table read, the sample read and the left and right products on the shared
// multiplier. Reset is synchronous and active low and clears the live and valid bits
// of the voice table; sample memory is not cleared. A word is taken only while the
// sequencer is idle, even while the previous result still waits at the output, and
// a finished result waits in the sequencer until the output register is free.
module multivoice_pcm_mixer #(
    parameter int VOICE_COUNT      = mvpm_pkg::VOICE_COUNT_DEF,
    parameter int SAMPLE_ADDR_BITS = mvpm_pkg::SAMPLE_ADDR_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input words.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // From bit 0: sample_address 16, sample_byte 8, sound_length 16, sound_id 16,
    // volume 7, separation 8, step 18, start_tick 31, play_once 1, keep_existing 1,
    // handle 16, zero padding 6.
    input  logic [mvpm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // From bit 0: kind 2.
    input  logic [1:0]                         s_axis_tuser,
    // Result words.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // From bit 0: left_sample 16, right_sample 16, mono_byte 8, voice_handle 16,
    // was_playing 1, level_clamped 1, zero padding 6.
    output logic [mvpm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // Configuration writes.
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_index,
    input  logic [4:0]                         i_cfg_data
);

    localparam int SB  = $clog2(VOICE_COUNT);
    localparam int VW  = $bits(mvpm_pkg::t_voice);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_WRITE  = 5'd1;
    localparam logic [4:0] S_ST_RD  = 5'd2;
    localparam logic [4:0] S_ST_CHK = 5'd3;
    localparam logic [4:0] S_ST_DEC = 5'd4;
    localparam logic [4:0] S_P0     = 5'd5;
    localparam logic [4:0] S_P1     = 5'd6;
    localparam logic [4:0] S_P2     = 5'd7;
    localparam logic [4:0] S_P3     = 5'd8;
    localparam logic [4:0] S_P4     = 5'd9;
    localparam logic [4:0] S_P5     = 5'd10;
    localparam logic [4:0] S_P6     = 5'd11;
    localparam logic [4:0] S_MX_RD  = 5'd12;
    localparam logic [4:0] S_MX_REC = 5'd13;
    localparam logic [4:0] S_MX_BYT = 5'd14;
    localparam logic [4:0] S_MX_ML  = 5'd15;
    localparam logic [4:0] S_MX_MR  = 5'd16;
    localparam logic [4:0] S_SP_RD  = 5'd17;
    localparam logic [4:0] S_SP_CHK = 5'd18;
    localparam logic [4:0] S_OUT    = 5'd19;

    // Control registers.
    logic [4:0]             r_state, n_state;
    logic [4:0]             r_active;
    logic [4:0]             r_master;
    logic                   r_eight;
    logic [VOICE_COUNT-1:0] r_live;
    logic [VOICE_COUNT-1:0] r_vvalid;
    logic                   r_rdv;
    logic                   r_ovalid;
    logic [SB:0]            r_i;

    // Item and working registers.
    logic [mvpm_pkg::IN_TDATA_W-1:0]  r_td;
    logic [1:0]                       r_kind;
    logic                             r_mfound, r_ffound, r_kill;
    logic [SB-1:0]                    r_midx, r_fidx, r_bidx, r_slot;
    logic [15:0]                      r_mtag, r_oldtag, r_res_handle;
    logic [30:0]                      r_btick;
    logic                             r_res_playing, r_clamp;
    logic [25:0]                      r_prod;
    logic [6:0]                       r_lvl_l, r_lvl_r, r_new_l;
    logic [7:0]                       r_mag;
    logic                             r_neg;
    logic signed [mvpm_pkg::ACC_W-1:0] r_acc_l, r_acc_r;
    logic [mvpm_pkg::OUT_TDATA_W-1:0] r_odata;

    // Fields of the held item.
    logic [15:0] w_addr, w_len, w_id, w_handle;
    logic [7:0]  w_byte, w_sep;
    logic [6:0]  w_vol;
    logic [17:0] w_step;
    logic [30:0] w_tick;
    logic        w_once, w_keep;

    assign w_addr   = r_td[15:0];
    assign w_byte   = r_td[23:16];
    assign w_len    = r_td[39:24];
    assign w_id     = r_td[55:40];
    assign w_vol    = r_td[62:56];
    assign w_sep    = r_td[70:63];
    assign w_step   = r_td[88:71];
    assign w_tick   = r_td[119:89];
    assign w_once   = r_td[120];
    assign w_keep   = r_td[121];
    assign w_handle = r_td[137:122];

    // Number of voices in use: zero acts as one, large counts saturate.
    logic [SB:0] w_n;
    always_comb begin
        if (r_active == 5'd0) begin
            w_n = (SB+1)'(1);
        end else if (32'(r_active) > 32'(VOICE_COUNT)) begin
            w_n = (SB+1)'(VOICE_COUNT);
        end else begin
            w_n = (SB+1)'(r_active);
        end
    end

    logic [SB-1:0] w_idx;
    assign w_idx = r_i[SB-1:0];

    // Voice table: one record per voice in RAM, valid bits in flops so that
    // never-written entries read as zero.
    logic                    w_vwe;
    logic [SB-1:0]           w_vwa, w_vra;
    mvpm_pkg::t_voice        w_vwd, w_vrd, w_rec;

    mvpm_ram #(
        .WIDTH (VW),
        .DEPTH (VOICE_COUNT)
    ) u_voice_ram (
        .i_clk   (i_clk),
        .i_we    (w_vwe),
        .i_waddr (w_vwa),
        .i_wdata (w_vwd),
        .i_raddr (w_vra),
        .o_rdata (w_vrd)
    );

    assign w_rec = r_rdv ? w_vrd : '0;

    // Sample memory.
    logic                        w_swe;
    logic [SAMPLE_ADDR_BITS-1:0] w_swa, w_sra;
    logic [7:0]                  w_srd;
    logic [31:0]                 w_sum_addr;

    assign w_sum_addr = 32'(w_rec.base) + 32'(w_rec.position);
    assign w_swe      = (r_state == S_WRITE);
    assign w_swa      = SAMPLE_ADDR_BITS'(32'(w_addr));
    assign w_sra      = w_sum_addr[SAMPLE_ADDR_BITS-1:0];

    mvpm_ram #(
        .WIDTH (8),
        .DEPTH (1 << SAMPLE_ADDR_BITS)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (w_swe),
        .i_waddr (w_swa),
        .i_wdata (w_byte),
        .i_raddr (w_sra),
        .o_rdata (w_srd)
    );

    // Voice stepping in 17.16 fixed point.
    logic [18:0] w_fsum;
    logic [16:0] w_npos;
    assign w_fsum = 19'(w_rec.fraction) + 19'(w_rec.rate);
    assign w_npos = w_rec.position + 17'(w_fsum[18:16]);

    // The shared multiplier.
    logic [16:0] w_mul_a;
    logic [8:0]  w_mul_b;
    logic [25:0] w_mul_p;
    logic [8:0]  w_pl, w_pr;
    logic signed [10:0] w_pan;
    logic [6:0]  w_lvl;
    logic        w_lvl_clamp;

    assign w_pl = 9'(w_sep) + 9'd1;
    assign w_pr = 9'd256 - 9'(w_sep);

    // Pan law on the registered product: level = volume - (volume*pos^2 >> 16).
    always_comb begin
        w_pan       = 11'(w_vol) - 11'(r_prod[25:16]);
        w_lvl_clamp = 1'b0;
        w_lvl       = w_pan[6:0];
        if (w_pan < 0) begin
            w_lvl       = 7'd0;
            w_lvl_clamp = 1'b1;
        end else if (w_pan > 11'(mvpm_pkg::LEVEL_MAX)) begin
            w_lvl       = mvpm_pkg::LEVEL_MAX;
            w_lvl_clamp = 1'b1;
        end
    end

    always_comb begin
        w_mul_a = 17'(w_pl);
        w_mul_b = w_pl;
        case (r_state)
            S_P1, S_P4: begin
                w_mul_a = r_prod[16:0];
                w_mul_b = 9'(w_vol);
            end
            S_P2, S_P5: begin
                w_mul_a = 17'(w_lvl);
                w_mul_b = 9'(r_master);
            end
            S_P3: begin
                w_mul_a = 17'(w_pr);
                w_mul_b = w_pr;
            end
            S_MX_BYT: begin
                w_mul_a = 17'(r_lvl_l);
                w_mul_b = 9'(w_srd[7] ? w_srd - mvpm_pkg::SILENCE
                                      : mvpm_pkg::SILENCE - w_srd);
            end
            S_MX_ML: begin
                w_mul_a = 17'(r_lvl_r);
                w_mul_b = 9'(r_mag);
            end
            default: begin
                w_mul_a = 17'(w_pl);
                w_mul_b = w_pl;
            end
        endcase
    end

    assign w_mul_p = 26'(w_mul_a * w_mul_b);

    // Level times master volume divided by 31.
    logic [27:0] w_d31;
    logic [6:0]  w_lvl_scaled;
    assign w_d31        = r_prod[11:0] * mvpm_pkg::DIV31_MUL;
    assign w_lvl_scaled = w_d31[26:20];

    // Scaled sample: level*(byte-128)*256/127, truncated toward zero, times four in eight-bit mode.
    logic [37:0]                        w_d127;
    logic signed [mvpm_pkg::ACC_W-1:0]  w_q, w_contrib;
    assign w_d127 = r_prod[13:0] * mvpm_pkg::DIV127_MUL;
    always_comb begin
        w_q       = mvpm_pkg::ACC_W'(w_d127[37:22]);
        w_contrib = r_neg ? -w_q : w_q;
        if (r_eight) begin
            w_contrib = w_contrib <<< 2;
        end
    end

    // Start: slot choice after the scan.
    logic [SB-1:0] w_choice;
    always_comb begin
        if (w_once && r_mfound) begin
            w_choice = (r_ffound && (r_fidx < r_midx)) ? r_fidx : r_midx;
        end else begin
            w_choice = r_ffound ? r_fidx : r_bidx;
        end
    end

    logic [15:0] w_newtag;
    assign w_newtag = {r_oldtag[15:SB] + (16-SB)'(1), r_slot};

    // Voice table port selection.
    always_comb begin
        w_vra = w_idx;
        case (r_state)
            S_P0:    w_vra = r_slot;
            S_SP_RD: w_vra = w_handle[SB-1:0];
            default: w_vra = w_idx;
        endcase
    end

    always_comb begin
        w_vwe = 1'b0;
        w_vwa = w_idx;
        w_vwd = w_rec;
        if (r_state == S_MX_REC) begin
            w_vwe          = 1'b1;
            w_vwd.position = w_npos;
            w_vwd.fraction = w_fsum[15:0];
        end else if (r_state == S_P6) begin
            w_vwe             = 1'b1;
            w_vwa             = r_slot;
            w_vwd.base        = w_addr;
            w_vwd.position    = '0;
            w_vwd.end_pos     = w_len;
            w_vwd.rate        = w_step;
            w_vwd.fraction    = '0;
            w_vwd.started     = w_tick;
            w_vwd.sound       = w_id;
            w_vwd.tag         = w_newtag;
            w_vwd.left_level  = r_new_l;
            w_vwd.right_level = w_lvl_scaled;
        end
    end

    logic w_stop_oob;
    assign w_stop_oob = (32'(w_handle[SB-1:0]) >= 32'(VOICE_COUNT));

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    case (s_axis_tuser)
                        mvpm_pkg::KIND_WRITE: n_state = S_WRITE;
                        mvpm_pkg::KIND_START: n_state = S_ST_RD;
                        mvpm_pkg::KIND_MIX:   n_state = S_MX_RD;
                        default:              n_state = S_SP_RD;
                    endcase
                end
            end
            S_WRITE:  n_state = S_OUT;
            S_ST_RD:  n_state = (r_i == w_n) ? S_ST_DEC : S_ST_CHK;
            S_ST_CHK: n_state = S_ST_RD;
            S_ST_DEC: n_state = (w_once && r_mfound && w_keep) ? S_OUT : S_P0;
            S_P0:     n_state = S_P1;
            S_P1:     n_state = S_P2;
            S_P2:     n_state = S_P3;
            S_P3:     n_state = S_P4;
            S_P4:     n_state = S_P5;
            S_P5:     n_state = S_P6;
            S_P6:     n_state = S_OUT;
            S_MX_RD: begin
                if (r_i == w_n) begin
                    n_state = S_OUT;
                end else if (r_live[w_idx]) begin
                    n_state = S_MX_REC;
                end
            end
            S_MX_REC: n_state = S_MX_BYT;
            S_MX_BYT: n_state = S_MX_ML;
            S_MX_ML:  n_state = S_MX_MR;
            S_MX_MR:  n_state = S_MX_RD;
            S_SP_RD:  n_state = w_stop_oob ? S_OUT : S_SP_CHK;
            S_SP_CHK: n_state = S_OUT;
            S_OUT:    n_state = (!r_ovalid || m_axis_tready) ? S_IDLE : S_OUT;
            default:  n_state = S_IDLE;
        endcase
    end

    // Result word assembled from the working registers.
    logic [15:0] w_sat_l, w_sat_r;
    logic [16:0] w_mono_sum;
    logic [mvpm_pkg::OUT_TDATA_W-1:0] w_result;
    assign w_sat_l    = mvpm_pkg::sat16(r_acc_l);
    assign w_sat_r    = mvpm_pkg::sat16(r_acc_r);
    assign w_mono_sum = 17'(w_sat_l ^ 16'h8000) + 17'(w_sat_r ^ 16'h8000);

    always_comb begin
        w_result = '0;
        case (r_kind)
            mvpm_pkg::KIND_MIX: begin
                w_result[15:0]  = w_sat_l;
                w_result[31:16] = w_sat_r;
                w_result[39:32] = r_eight ? w_mono_sum[16:9] : 8'd0;
            end
            mvpm_pkg::KIND_START: begin
                w_result[55:40] = r_res_handle;
                w_result[57]    = r_clamp;
            end
            mvpm_pkg::KIND_STOP: begin
                w_result[56] = r_res_playing;
            end
            default: w_result = '0;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= mvpm_pkg::ACTIVE_VOICES_RST;
            r_master <= mvpm_pkg::MASTER_VOLUME_RST;
            r_eight  <= 1'b0;
            r_live   <= '0;
            r_vvalid <= '0;
            r_rdv    <= 1'b0;
            r_ovalid <= 1'b0;
            r_i      <= '0;
        end else begin
            r_state <= n_state;
            r_rdv   <= r_vvalid[w_vra];
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mvpm_pkg::CFG_ACTIVE_VOICES:  r_active <= i_cfg_data;
                    mvpm_pkg::CFG_MASTER_VOLUME:  r_master <= i_cfg_data;
                    mvpm_pkg::CFG_EIGHT_BIT_MODE: r_eight  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_state == S_IDLE) begin
                r_i <= '0;
            end else if (r_state == S_ST_CHK || r_state == S_MX_MR ||
                         (r_state == S_MX_RD && r_i != w_n && !r_live[w_idx])) begin
                r_i <= r_i + (SB+1)'(1);
            end
            if (r_state == S_MX_REC && ({1'b0, w_npos} > {2'b0, w_rec.end_pos} ||
                                        w_npos == {1'b0, w_rec.end_pos})) begin
                r_live[w_idx] <= 1'b0;
            end
            if (r_state == S_P6) begin
                if (r_kill) begin
                    r_live[r_midx] <= 1'b0;
                end
                r_live[r_slot]   <= 1'b1;
                r_vvalid[r_slot] <= 1'b1;
            end
            if (r_state == S_SP_CHK && w_rec.tag == w_handle) begin
                r_live[w_handle[SB-1:0]] <= 1'b0;
            end
            if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_td          <= s_axis_tdata;
            r_kind        <= s_axis_tuser;
            r_mfound      <= 1'b0;
            r_ffound      <= 1'b0;
            r_kill        <= 1'b0;
            r_bidx        <= '0;
            r_btick       <= mvpm_pkg::TICK_MAX;
            r_res_playing <= 1'b0;
            r_clamp       <= 1'b0;
            r_acc_l       <= '0;
            r_acc_r       <= '0;
        end
        case (r_state)
            S_ST_CHK: begin
                if (w_once && !r_mfound && r_live[w_idx] && w_rec.sound == w_id) begin
                    r_mfound <= 1'b1;
                    r_midx   <= w_idx;
                    r_mtag   <= w_rec.tag;
                end
                if (!r_ffound) begin
                    if (!r_live[w_idx]) begin
                        r_ffound <= 1'b1;
                        r_fidx   <= w_idx;
                    end else if (w_rec.started < r_btick) begin
                        r_bidx  <= w_idx;
                        r_btick <= w_rec.started;
                    end
                end
            end
            S_ST_DEC: begin
                r_slot       <= w_choice;
                r_kill       <= w_once && r_mfound;
                r_res_handle <= r_mtag;
            end
            S_P0: r_prod <= w_mul_p;
            S_P1: begin
                r_oldtag <= w_rec.tag;
                r_prod   <= w_mul_p;
            end
            S_P2, S_P5: begin
                r_clamp <= r_clamp | w_lvl_clamp;
                r_prod  <= w_mul_p;
            end
            S_P3: begin
                r_new_l <= w_lvl_scaled;
                r_prod  <= w_mul_p;
            end
            S_P4: r_prod <= w_mul_p;
            S_P6: r_res_handle <= w_newtag;
            S_MX_REC: begin
                r_lvl_l <= w_rec.left_level;
                r_lvl_r <= w_rec.right_level;
            end
            S_MX_BYT: begin
                r_mag  <= w_mul_b[7:0];
                r_neg  <= ~w_srd[7];
                r_prod <= w_mul_p;
            end
            S_MX_ML: begin
                r_acc_l <= r_acc_l + w_contrib;
                r_prod  <= w_mul_p;
            end
            S_MX_MR: r_acc_r <= r_acc_r + w_contrib;
            S_SP_CHK: begin
                if (w_rec.tag == w_handle) begin
                    r_res_playing <= r_live[w_handle[SB-1:0]];
                end
            end
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    r_odata <= w_result;
                end
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

[sv/mvpm_checker.sv]
// Port-level checks of the multi-voice PCM mixer, bound to the top level.
// Depends on multivoice_pcm_mixer_defines.svh and mvpm_pkg.
`include "multivoice_pcm_mixer_defines.svh"

module mvpm_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [mvpm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [1:0]                       s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [mvpm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             i_cfg_we,
    input logic [1:0]                       i_cfg_index,
    input logic [4:0]                       i_cfg_data
);

    // A waiting result word holds until it is taken.
    `MVPM_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // After a transfer the sequencer leaves the idle state, so the input closes.
    `MVPM_ASSERT_NXT(a_in_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A start result carries no mix and no stop status.
    `MVPM_ASSERT_IMP(a_start_only, m_axis_tvalid && (m_axis_tdata[55:40] != 16'h0), (m_axis_tdata[39:0] == 40'h0) && !m_axis_tdata[56])

    // The squared pan law never leaves the level range.
    `MVPM_ASSERT_IMP(a_no_clamp, m_axis_tvalid, !m_axis_tdata[57])

endmodule

bind multivoice_pcm_mixer mvpm_checker u_mvpm_checker (.*);
